[sv/tsps_pkg.sv]
package tsps_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SERVO1_REST = 3'd0;
    localparam logic [2:0] REG_SERVO2_REST = 3'd1;
    localparam logic [2:0] REG_SERVO1_LIFT = 3'd2;
    localparam logic [2:0] REG_SERVO2_PUSH = 3'd3;
    localparam logic [2:0] REG_DELAY_A     = 3'd4;
    localparam logic [2:0] REG_DELAY_B     = 3'd5;
    localparam logic [2:0] REG_DELAY_C     = 3'd6;

    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned INDEX_W = 3;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

    localparam logic [ANGLE_W-1:0] SERVO1_REST_RST = 8'd0;
    localparam logic [ANGLE_W-1:0] SERVO2_REST_RST = 8'd0;
    localparam logic [ANGLE_W-1:0] SERVO1_LIFT_RST = 8'd90;
    localparam logic [ANGLE_W-1:0] SERVO2_PUSH_RST = 8'd90;
    localparam logic [DELAY_W-1:0] DELAY_A_RST     = 16'd1500;
    localparam logic [DELAY_W-1:0] DELAY_B_RST     = 16'd1600;
    localparam logic [DELAY_W-1:0] DELAY_C_RST     = 16'd1700;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo1_rest_angle;
        logic [ANGLE_W-1:0] servo2_rest_angle;
        logic [ANGLE_W-1:0] servo1_lift_angle;
        logic [ANGLE_W-1:0] servo2_push_angle;
        logic [DELAY_W-1:0] delay_a_ms;
        logic [DELAY_W-1:0] delay_b_ms;
        logic [DELAY_W-1:0] delay_c_ms;
    } cfg_t;

    typedef struct packed {
        logic               done_res;
        logic               busy_res;
        logic [ANGLE_W-1:0] servo2_angle;
        logic [ANGLE_W-1:0] servo1_angle;
    } res_t;

endpackage

[sv/tsps_cfg.sv]
module tsps_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tsps_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [tsps_pkg::DELAY_W-1:0]  cfg_data,
    output tsps_pkg::cfg_t                cfg
);

    tsps_pkg::cfg_t                cfg_reg;
    tsps_pkg::cfg_t                cfg_next;
    logic [tsps_pkg::ANGLE_W-1:0]  angle;
    logic                          angle_ok;

    // Angle writes above the servo range leave the register untouched.
    assign angle    = cfg_data[tsps_pkg::ANGLE_W-1:0];
    assign angle_ok = (angle <= tsps_pkg::ANGLE_MAX);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                tsps_pkg::REG_SERVO1_REST: if (angle_ok) cfg_next.servo1_rest_angle = angle;
                tsps_pkg::REG_SERVO2_REST: if (angle_ok) cfg_next.servo2_rest_angle = angle;
                tsps_pkg::REG_SERVO1_LIFT: if (angle_ok) cfg_next.servo1_lift_angle = angle;
                tsps_pkg::REG_SERVO2_PUSH: if (angle_ok) cfg_next.servo2_push_angle = angle;
                tsps_pkg::REG_DELAY_A:     cfg_next.delay_a_ms = cfg_data;
                tsps_pkg::REG_DELAY_B:     cfg_next.delay_b_ms = cfg_data;
                tsps_pkg::REG_DELAY_C:     cfg_next.delay_c_ms = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.servo1_rest_angle <= tsps_pkg::SERVO1_REST_RST;
            cfg_reg.servo2_rest_angle <= tsps_pkg::SERVO2_REST_RST;
            cfg_reg.servo1_lift_angle <= tsps_pkg::SERVO1_LIFT_RST;
            cfg_reg.servo2_push_angle <= tsps_pkg::SERVO2_PUSH_RST;
            cfg_reg.delay_a_ms        <= tsps_pkg::DELAY_A_RST;
            cfg_reg.delay_b_ms        <= tsps_pkg::DELAY_B_RST;
            cfg_reg.delay_c_ms        <= tsps_pkg::DELAY_C_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/tsps_seq.sv]
module tsps_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic                         action,
    input  logic [tsps_pkg::TIME_W-1:0]  now_ms,
    input  tsps_pkg::cfg_t               cfg,
    output tsps_pkg::res_t               res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LIFT,
        PH_WAIT_PUSH,
        PH_WAIT_RET2,
        PH_WAIT_RET1
    } phase_t;

    phase_t                        phase_reg,  phase_next;
    logic [tsps_pkg::TIME_W-1:0]   mark_reg,   mark_next;
    logic                          busy_reg,   busy_next;
    logic [tsps_pkg::ANGLE_W-1:0]  servo1_reg, servo1_next;
    logic [tsps_pkg::ANGLE_W-1:0]  servo2_reg, servo2_next;
    logic                          done_next;
    tsps_pkg::res_t                res_reg,    res_next;
    logic [tsps_pkg::TIME_W-1:0]   elapsed;
    logic [tsps_pkg::DELAY_W-1:0]  limit;
    logic                          expired;

    // Wrapping difference against the mark left by the previous step.
    assign elapsed = now_ms - mark_reg;

    always_comb begin
        case (phase_reg)
            PH_WAIT_PUSH: limit = cfg.delay_a_ms;
            PH_WAIT_RET2: limit = cfg.delay_b_ms;
            default:      limit = cfg.delay_c_ms;
        endcase
    end

    assign expired = (elapsed > {{(tsps_pkg::TIME_W-tsps_pkg::DELAY_W){1'b0}}, limit});

    always_comb begin
        phase_next  = phase_reg;
        mark_next   = mark_reg;
        busy_next   = busy_reg;
        servo1_next = servo1_reg;
        servo2_next = servo2_reg;
        done_next   = 1'b0;
        if (action) begin
            // A push request restarts the sequence, even mid-run.
            phase_next = PH_LIFT;
            busy_next  = 1'b1;
        end else begin
            case (phase_reg)
                PH_LIFT: begin
                    servo1_next = cfg.servo1_lift_angle;
                    mark_next   = now_ms;
                    phase_next  = PH_WAIT_PUSH;
                end
                PH_WAIT_PUSH: begin
                    if (expired) begin
                        servo2_next = cfg.servo2_push_angle;
                        mark_next   = now_ms;
                        phase_next  = PH_WAIT_RET2;
                    end
                end
                PH_WAIT_RET2: begin
                    if (expired) begin
                        servo2_next = cfg.servo2_rest_angle;
                        mark_next   = now_ms;
                        phase_next  = PH_WAIT_RET1;
                    end
                end
                PH_WAIT_RET1: begin
                    if (expired) begin
                        servo1_next = cfg.servo1_rest_angle;
                        mark_next   = now_ms;
                        phase_next  = PH_IDLE;
                        busy_next   = 1'b0;
                        done_next   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res_next.servo1_angle = servo1_next;
        res_next.servo2_angle = servo2_next;
        res_next.busy_res     = busy_next;
        res_next.done_res     = done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            mark_reg   <= '0;
            busy_reg   <= 1'b0;
            servo1_reg <= tsps_pkg::SERVO1_REST_RST;
            servo2_reg <= tsps_pkg::SERVO2_REST_RST;
        end else if (advance) begin
            phase_reg  <= phase_next;
            mark_reg   <= mark_next;
            busy_reg   <= busy_next;
            servo1_reg <= servo1_next;
            servo2_reg <= servo2_next;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[sv/two_servo_push_sequencer.sv]
// Channel   | Direction | tdata                              | tuser
// s_ (in)   | request   | now_ms[31:0]                       | action (1 = push request)
// m_ (out)  | result    | servo1[7:0] servo2[15:8] busy[16]  | none
//           |           | done[17], zero pad [23:18]         |
// cfg_      | write     | cfg_index selects, cfg_data[15:0]  | none
//
// One request enters per cycle while no stall on m_tready holds it back, and one result
// leaves per request. A taken request is held in the input register, then passes through
// the sequencer logic into the result register. The single subtract-and-compare on the
// elapsed time sets the rate. Reset is synchronous and active low; it restores the
// register defaults and parks both servos at their rest angles. A stall on m_tready
// holds the result register, and the input register fills behind it before s_tready drops.
module two_servo_push_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input requests.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,    // now_ms[31:0]
    input  logic                          s_tuser,    // action
    // Results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,    // servo1_angle[7:0], servo2_angle[15:8],
                                                      // busy_res[16], done_res[17], zeros
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [tsps_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [tsps_pkg::DELAY_W-1:0]  cfg_data
);

    logic                         in_valid_reg;
    logic                         in_action_reg;
    logic [tsps_pkg::TIME_W-1:0]  in_now_reg;
    logic                         out_valid_reg;
    logic                         advance;
    tsps_pkg::cfg_t               cfg;
    tsps_pkg::res_t               res;

    // The held request moves on whenever the result register is free or being emptied,
    // so the input register can take a new request in that same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_now_reg    <= s_tdata;
        end
    end

    tsps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsps_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .action  (in_action_reg),
        .now_ms  (in_now_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res.done_res, res.busy_res, res.servo2_angle, res.servo1_angle};

endmodule

[sv/tsps_check.sv]
module tsps_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Nothing is offered in the cycle after a reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // Completion clears busy in the same result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[17] && m_tdata[16]))
        else $error("done reported while still busy");

    // Commanded angles never leave the servo range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= 8'd180) && (m_tdata[15:8] <= 8'd180))
        else $error("servo angle out of range");

    // A stalled result stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind two_servo_push_sequencer tsps_check u_tsps_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/two_servo_push_sequencer_test.sv]
module two_servo_push_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds carried on s_tuser.
    localparam logic ACT_POLL = 1'b0;
    localparam logic ACT_PUSH = 1'b1;

    // Index 7 has no register behind it; writes to it must change nothing.
    localparam logic [tsps_pkg::INDEX_W-1:0] REG_NONE = 3'd7;

    // A result passes through the input register and then the result register.
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LIFT,
        SEQ_WAIT_PUSH,
        SEQ_WAIT_RET2,
        SEQ_WAIT_RET1
    } seq_phase_t;

    typedef struct packed {
        logic                        action;
        logic [tsps_pkg::TIME_W-1:0] now_ms;
    } request_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata   = '0;     // now_ms[31:0]
    logic                          s_tuser   = 1'b0;   // action
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [23:0]                   m_tdata;            // servo1_angle[7:0], servo2_angle[15:8],
                                                       // busy_res[16], done_res[17], zeros
    logic                          cfg_we    = 1'b0;
    logic [tsps_pkg::INDEX_W-1:0]  cfg_index = '0;
    logic [tsps_pkg::DELAY_W-1:0]  cfg_data  = '0;

    two_servo_push_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the register file and of the sequencer state.
    tsps_pkg::cfg_t                cfg_mirror;
    seq_phase_t                    seq_phase;
    logic [tsps_pkg::TIME_W-1:0]   time_mark;
    logic                          in_progress;
    logic [tsps_pkg::ANGLE_W-1:0]  servo1_cmd;
    logic [tsps_pkg::ANGLE_W-1:0]  servo2_cmd;

    // Stimulus waiting to be offered, and the servo poses still owed by the block.
    request_t       pending_requests[$];
    tsps_pkg::res_t expected_pose[$];
    request_t       next_req;
    tsps_pkg::res_t want_pose;
    tsps_pkg::res_t got_pose;

    // Millisecond clock that the polls carry, moved on by each poll's gap.
    logic [tsps_pkg::TIME_W-1:0] wall_ms;

    int queued_count   = 0;
    int accepted_count = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    // Percent of cycles in which each side holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Advance the sequencer by one request and return the pose it reports.
    // A push request only arms the sequence; each poll moves at most one step,
    // and every timed step must see strictly more than its delay since the last one.
    function automatic tsps_pkg::res_t step_sequencer(
        input logic                        action,
        input logic [tsps_pkg::TIME_W-1:0] now
    );
        logic [tsps_pkg::TIME_W-1:0] elapsed;
        logic                        finished;
        tsps_pkg::res_t              pose;
        elapsed  = now - time_mark;
        finished = 1'b0;
        if (action == ACT_PUSH) begin
            seq_phase   = SEQ_LIFT;
            in_progress = 1'b1;
        end else begin
            case (seq_phase)
                SEQ_LIFT: begin
                    servo1_cmd = cfg_mirror.servo1_lift_angle;
                    time_mark  = now;
                    seq_phase  = SEQ_WAIT_PUSH;
                end
                SEQ_WAIT_PUSH: begin
                    if (elapsed > {16'd0, cfg_mirror.delay_a_ms}) begin
                        servo2_cmd = cfg_mirror.servo2_push_angle;
                        time_mark  = now;
                        seq_phase  = SEQ_WAIT_RET2;
                    end
                end
                SEQ_WAIT_RET2: begin
                    if (elapsed > {16'd0, cfg_mirror.delay_b_ms}) begin
                        servo2_cmd = cfg_mirror.servo2_rest_angle;
                        time_mark  = now;
                        seq_phase  = SEQ_WAIT_RET1;
                    end
                end
                SEQ_WAIT_RET1: begin
                    if (elapsed > {16'd0, cfg_mirror.delay_c_ms}) begin
                        servo1_cmd  = cfg_mirror.servo1_rest_angle;
                        time_mark   = now;
                        seq_phase   = SEQ_IDLE;
                        in_progress = 1'b0;
                        finished    = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        pose.servo1_angle = servo1_cmd;
        pose.servo2_angle = servo2_cmd;
        pose.busy_res     = in_progress;
        pose.done_res     = finished;
        return pose;
    endfunction

    // Driver: offers the oldest pending request. A new one is only placed on the bus
    // once the current one has been taken, so s_tvalid gets one assignment per edge
    // and stays high across back-to-back requests.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pose.push_back(step_sequencer(s_tuser, s_tdata));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.action;
                    s_tdata  <= next_req.now_ms;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: every result taken is matched against the oldest owed pose.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pose.size() == 0) begin
                    $error("result with no request waiting: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want_pose = expected_pose.pop_front();
                    got_pose  = m_tdata[17:0];
                    check_field("servo1_angle", want_pose.servo1_angle, got_pose.servo1_angle);
                    check_field("servo2_angle", want_pose.servo2_angle, got_pose.servo2_angle);
                    check_field("busy_res", want_pose.busy_res, got_pose.busy_res);
                    check_field("done_res", want_pose.done_res, got_pose.done_res);
                    check_field("m_tdata padding", 0, m_tdata[23:18]);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // A hung handshake would otherwise leave the run waiting forever.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_request(input logic action, input logic [tsps_pkg::TIME_W-1:0] now);
        request_t req;
        req.action = action;
        req.now_ms = now;
        pending_requests.push_back(req);
        queued_count++;
    endtask

    task automatic queue_poll(input logic [tsps_pkg::TIME_W-1:0] gap);
        wall_ms = wall_ms + gap;
        queue_request(ACT_POLL, wall_ms);
    endtask

    // A push request ignores the time it carries, so any value will do.
    task automatic queue_push();
        queue_request(ACT_PUSH, $urandom);
    endtask

    // Register write, mirrored at once. Angles keep their old value when the low
    // byte of the data is above the servo range; the delays take all 16 bits.
    task automatic write_register(input logic [tsps_pkg::INDEX_W-1:0] index,
                                  input logic [tsps_pkg::DELAY_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            tsps_pkg::REG_SERVO1_REST: begin
                if (data[7:0] <= tsps_pkg::ANGLE_MAX) cfg_mirror.servo1_rest_angle = data[7:0];
            end
            tsps_pkg::REG_SERVO2_REST: begin
                if (data[7:0] <= tsps_pkg::ANGLE_MAX) cfg_mirror.servo2_rest_angle = data[7:0];
            end
            tsps_pkg::REG_SERVO1_LIFT: begin
                if (data[7:0] <= tsps_pkg::ANGLE_MAX) cfg_mirror.servo1_lift_angle = data[7:0];
            end
            tsps_pkg::REG_SERVO2_PUSH: begin
                if (data[7:0] <= tsps_pkg::ANGLE_MAX) cfg_mirror.servo2_push_angle = data[7:0];
            end
            tsps_pkg::REG_DELAY_A: cfg_mirror.delay_a_ms = data;
            tsps_pkg::REG_DELAY_B: cfg_mirror.delay_b_ms = data;
            tsps_pkg::REG_DELAY_C: cfg_mirror.delay_c_ms = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input int s1_rest, input int s2_rest, input int s1_lift,
                                 input int s2_push, input int dly_a, input int dly_b,
                                 input int dly_c);
        write_register(tsps_pkg::REG_SERVO1_REST, 16'(s1_rest));
        write_register(tsps_pkg::REG_SERVO2_REST, 16'(s2_rest));
        write_register(tsps_pkg::REG_SERVO1_LIFT, 16'(s1_lift));
        write_register(tsps_pkg::REG_SERVO2_PUSH, 16'(s2_push));
        write_register(tsps_pkg::REG_DELAY_A, 16'(dly_a));
        write_register(tsps_pkg::REG_DELAY_B, 16'(dly_b));
        write_register(tsps_pkg::REG_DELAY_C, 16'(dly_c));
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every pose has come back, then let the
    // pipeline settle. Sampling on the falling edge keeps clear of the clocked blocks.
    task automatic drain();
        while (accepted_count != queued_count || expected_pose.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    // Time between polls. Most gaps are drawn against the current delays so that
    // sequences run to completion; some land exactly on or just past a delay, and
    // some are huge so the elapsed time wraps or looks far in the future.
    function automatic logic [tsps_pkg::TIME_W-1:0] pick_gap();
        int span;
        span = cfg_mirror.delay_a_ms;
        if (cfg_mirror.delay_b_ms > span) span = cfg_mirror.delay_b_ms;
        if (cfg_mirror.delay_c_ms > span) span = cfg_mirror.delay_c_ms;
        case ($urandom_range(11))
            0: return '0;
            1: return 32'd1;
            5: return cfg_mirror.delay_a_ms + $urandom_range(2);
            6: return cfg_mirror.delay_b_ms + $urandom_range(2);
            7: return cfg_mirror.delay_c_ms + $urandom_range(2);
            8: return $urandom;
            9: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(2 * span + 2);
        endcase
    endfunction

    // Mostly whole push sequences with random timing; some of them are cut short
    // by a fresh push request, and the rest is stray polls and lone pushes.
    task automatic plan_random(input int target);
        int made;
        int polls;
        made = 0;
        while (made < target) begin
            case ($urandom_range(9))
                0: begin
                    queue_poll(pick_gap());
                    made++;
                end
                1: begin
                    queue_push();
                    made++;
                end
                default: begin
                    queue_push();
                    made++;
                    polls = $urandom_range(4, 16);
                    repeat (polls) begin
                        if ($urandom_range(15) == 0) queue_push();
                        else queue_poll(pick_gap());
                        made++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        // Register defaults and the parked servos that reset establishes.
        cfg_mirror = '{tsps_pkg::SERVO1_REST_RST, tsps_pkg::SERVO2_REST_RST,
                       tsps_pkg::SERVO1_LIFT_RST, tsps_pkg::SERVO2_PUSH_RST,
                       tsps_pkg::DELAY_A_RST, tsps_pkg::DELAY_B_RST,
                       tsps_pkg::DELAY_C_RST};
        seq_phase   = SEQ_IDLE;
        time_mark   = '0;
        in_progress = 1'b0;
        servo1_cmd  = tsps_pkg::SERVO1_REST_RST;
        servo2_cmd  = tsps_pkg::SERVO2_REST_RST;
        wall_ms     = 32'hFFFF_FFF0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 77;

        // Directed run on the default settings. Each timed step is first polled
        // exactly at its delay, which must not advance, then one ms later.
        // The clock starts just below the wrap point so the first wait crosses it.
        queue_poll(0);                         // poll while idle changes nothing
        queue_request(ACT_PUSH, 32'hFFFF_FFFF);
        queue_poll(0);                         // servo 1 lifts, time is marked
        queue_poll(32'(tsps_pkg::DELAY_A_RST));
        queue_poll(1);                         // servo 2 pushes, after the wrap
        queue_poll(32'(tsps_pkg::DELAY_B_RST));
        queue_poll(1);                         // servo 2 back to rest
        queue_poll(32'(tsps_pkg::DELAY_C_RST));
        queue_poll(1);                         // servo 1 back to rest, done pulses
        queue_poll(0);
        queue_push();
        queue_push();                          // repeated push while armed
        queue_poll(5);
        queue_poll(2000);
        queue_push();                          // restart in the middle of a sequence
        queue_poll(0);                         // servo 1 driven to lift again
        queue_poll(32'h8000_0000);
        queue_request(ACT_PUSH, 32'h0000_0000);
        drain();

        // Extreme settings. Out-of-range angle writes and the unused index must be
        // ignored; an angle write with high data bits set keeps only its low byte.
        // The sequence above is left armed, so these changes only affect later drives.
        load_settings(180, 0, 0, 180, 0, 0, 65535);
        write_register(tsps_pkg::REG_SERVO2_REST, 16'd181);
        write_register(tsps_pkg::REG_SERVO1_LIFT, 16'd255);
        write_register(tsps_pkg::REG_SERVO2_PUSH, 16'hFFB4);
        write_register(tsps_pkg::REG_SERVO2_REST, 16'h0100);
        write_register(REG_NONE, 16'hFFFF);
        end_writes();

        queue_push();
        queue_poll(0);                         // lift
        queue_poll(0);                         // zero delay still needs one ms
        queue_poll(1);
        queue_poll(1);
        queue_poll(65535);
        queue_poll(1);                         // longest delay just exceeded
        drain();

        // Random phase with short delays, so most sequences finish.
        load_settings($urandom_range(180), $urandom_range(180), $urandom_range(180),
                      $urandom_range(180), $urandom_range(12), $urandom_range(12),
                      $urandom_range(12));
        end_writes();
        plan_random(350);
        drain();

        // Swap the idling and move to delays at both ends of their range.
        send_idle_pct = 77;
        recv_idle_pct = 12;
        load_settings(0, 180, 180, 0,
                      $urandom_range(1) ? 65535 : 0,
                      $urandom_range(1) ? 65535 : $urandom_range(3),
                      $urandom_range(1) ? 65534 : 1);
        end_writes();
        plan_random(350);
        drain();

        // Full throughput, with angle writes that may or may not be in range.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(40), $urandom_range(40),
                      $urandom_range(40));
        write_register(tsps_pkg::REG_SERVO1_LIFT, 16'($urandom));
        write_register(REG_NONE, 16'($urandom));
        end_writes();
        plan_random(350);
        drain();

        if (expected_pose.size() != 0) begin
            $error("%0d results never arrived", expected_pose.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/tsps_pkg.sv
sv/tsps_cfg.sv
sv/tsps_seq.sv
sv/two_servo_push_sequencer.sv
sv/tsps_check.sv
bench/two_servo_push_sequencer_test.sv
